// ===== design/tsrm_pkg.sv =====
// tsrm_pkg: shared types and constants for the top-k shard result merge.
// No dependencies; compile first.
`default_nettype none

package tsrm_pkg;

    localparam int ID_W   = 32;
    localparam int DIST_W = 32;
    localparam int TOPK_W = 5;

    localparam logic [TOPK_W-1:0] TOPK_RESET = 5'd10;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT
    } tsrm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic store;
        logic scan_issue;
        logic emit;
        logic clear;
    } tsrm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic shards_zero;
        logic scan_last;
        logic res_last;
        logic out_free;
    } tsrm_stat_t;

endpackage

`default_nettype wire

// ===== design/tsrm_in_if.sv =====
// tsrm_in_if: valid/ready channel carrying one shard list entry per request.
// Depends on tsrm_pkg.
`default_nettype none

interface tsrm_in_if;
    import tsrm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   entry_id;
    logic [DIST_W-1:0] distance;
    logic              last_entry;

    modport source (output valid, output entry_id, output distance, output last_entry,
                    input ready);
    modport sink   (input valid, input entry_id, input distance, input last_entry,
                    output ready);
endinterface

`default_nettype wire

// ===== design/tsrm_out_if.sv =====
// tsrm_out_if: valid/ready channel carrying one merged neighbor id per request.
// Depends on tsrm_pkg.
`default_nettype none

interface tsrm_out_if;
    import tsrm_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] neighbor_id;
    logic            last_result;

    modport source (output valid, output neighbor_id, output last_result, input ready);
    modport sink   (input valid, input neighbor_id, input last_result, output ready);
endinterface

`default_nettype wire

// ===== design/topk_shard_result_merge.sv =====
// topk_shard_result_merge: k-way merge of per-shard ascending top-k lists.
// Depends on tsrm_pkg, tsrm_in_if, tsrm_out_if, tsrm_ctrl, tsrm_dpath.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          entry_id[31:0] distance[31:0] last_entry
//  out_ch    out  valid/ready          neighbor_id[31:0] last_result
//  cfg       in   cfg_wr_en (no wait)  cfg_wr_data[4:0] = top_k
//
// Load: one request per cycle while in the load state; each is written into the
//   entry stores until they are full, later ones are dropped.
// Merge: per result, a scan step reads one shard head a cycle over the complete
//   shards through the single read port of the entry stores, then a compare step
//   and an emit step follow; with no complete shard the merge yields no result.
// Reset clears the counters and shard heads and sets top_k to 10; stores need no clear.
// A stalled output holds the merge in its emit step; input is taken again once
//   the last result sits in the output register.
`default_nettype none

module topk_shard_result_merge #(
    parameter int MAX_K      = 16,
    parameter int MAX_SHARDS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [tsrm_pkg::TOPK_W-1:0] cfg_wr_data,
    tsrm_in_if.sink                          in_ch,
    tsrm_out_if.source                       out_ch
);
    import tsrm_pkg::*;

    tsrm_cmd_t  cmd;
    tsrm_stat_t stat;

    // sequencer: decides when requests are taken and when a pick is emitted
    tsrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last_entry),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // stores, shard heads, running-min compare and output register
    tsrm_dpath #(
        .MAX_K      (MAX_K),
        .MAX_SHARDS (MAX_SHARDS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .entry_id    (in_ch.entry_id),
        .distance    (in_ch.distance),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .neighbor_id (out_ch.neighbor_id),
        .last_result (out_ch.last_result)
    );

endmodule

`default_nettype wire

// ===== design/tsrm_ctrl.sv =====
// tsrm_ctrl: load / scan / emit sequencer for the shard merge.
// Depends on tsrm_pkg.
`default_nettype none

module tsrm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    output logic                    in_ready,
    output tsrm_pkg::tsrm_cmd_t     cmd,
    input  wire tsrm_pkg::tsrm_stat_t stat
);
    import tsrm_pkg::*;

    tsrm_state_t state_reg;
    tsrm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.shards_zero ? ST_LOAD : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.res_last ? ST_LOAD : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.store      = 1'b0;
        cmd.scan_issue = 1'b0;
        cmd.emit       = 1'b0;
        cmd.clear      = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
            end
            ST_CHECK:
            begin
                cmd.clear = stat.shards_zero;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            ST_WAIT:
            begin
                cmd.store = 1'b0;
            end
            ST_EMIT:
            begin
                cmd.emit  = stat.out_free;
                cmd.clear = stat.out_free && stat.res_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tsrm_dpath.sv =====
// tsrm_dpath: entry stores, shard heads, min-scan compare and result register.
// Depends on tsrm_pkg.
`default_nettype none

module tsrm_dpath #(
    parameter int MAX_K      = 16,
    parameter int MAX_SHARDS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tsrm_pkg::TOPK_W-1:0]   cfg_wr_data,
    input  wire logic [tsrm_pkg::ID_W-1:0]     entry_id,
    input  wire logic [tsrm_pkg::DIST_W-1:0]   distance,
    input  wire tsrm_pkg::tsrm_cmd_t           cmd,
    output tsrm_pkg::tsrm_stat_t               stat,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [tsrm_pkg::ID_W-1:0]          neighbor_id,
    output logic                               last_result
);
    import tsrm_pkg::*;

    localparam int DEPTH = MAX_K * MAX_SHARDS;
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int SW    = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
    localparam int SCW   = $clog2(MAX_SHARDS + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);

    logic [ID_W-1:0]   id_mem   [DEPTH];
    logic [DIST_W-1:0] dist_mem [DEPTH];

    logic [TOPK_W-1:0] top_k_reg;
    logic [KW-1:0]     k_eff;

    logic [LW-1:0]     load_count_reg;
    logic [KW-1:0]     pos_reg;
    logic [SCW-1:0]    shard_cnt_reg;
    logic [KW-1:0]     head_reg [MAX_SHARDS];

    logic [SW-1:0]     scan_s_reg;
    logic [KW-1:0]     r_reg;

    logic              p_valid_reg;
    logic [SW-1:0]     p_s_reg;
    logic [KW-1:0]     p_h_reg;
    logic [ID_W-1:0]   rd_id_reg;
    logic [DIST_W-1:0] rd_d_reg;

    logic              best_found_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [SW-1:0]     best_s_reg;
    logic [KW-1:0]     best_h_reg;

    logic              out_valid_reg;
    logic [ID_W-1:0]   neighbor_id_reg;
    logic              last_result_reg;

    logic              stored;
    logic [KW-1:0]     cur_head;
    logic              cur_live;
    logic [AW-1:0]     rd_addr;
    logic              take;

    // top_k of zero acts as one, above MAX_K saturates
    always_comb
    begin
        if (top_k_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(top_k_reg) > MAX_K)
        begin
            k_eff = KW'(MAX_K);
        end
        else
        begin
            k_eff = KW'(top_k_reg);
        end
    end

    assign stored   = cmd.store && (load_count_reg != LW'(DEPTH));
    assign cur_head = head_reg[scan_s_reg];
    assign cur_live = cur_head < k_eff;
    assign rd_addr  = AW'(scan_s_reg) * AW'(k_eff) + AW'(cur_head);
    assign take     = p_valid_reg && (!best_found_reg || (rd_d_reg < best_d_reg));

    assign stat.shards_zero = (shard_cnt_reg == '0);
    assign stat.scan_last   = (SCW'(scan_s_reg) == (shard_cnt_reg - SCW'(1)));
    assign stat.res_last    = (r_reg == (k_eff - KW'(1)));
    assign stat.out_free    = !out_valid_reg || out_ready;

    // entry stores: one write port (load), one registered read port (scan)
    always_ff @(posedge clk)
    begin
        if (stored)
        begin
            id_mem[AW'(load_count_reg)]   <= entry_id;
            dist_mem[AW'(load_count_reg)] <= distance;
        end
        rd_id_reg <= id_mem[rd_addr];
        rd_d_reg  <= dist_mem[rd_addr];
        p_s_reg   <= scan_s_reg;
        p_h_reg   <= cur_head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_k_reg <= TOPK_RESET;
        end
        else if (cfg_wr_en)
        begin
            top_k_reg <= cfg_wr_data;
        end
    end

    // load bookkeeping: shard count kept incrementally
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            pos_reg        <= '0;
            shard_cnt_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            load_count_reg <= '0;
            pos_reg        <= '0;
            shard_cnt_reg  <= '0;
        end
        else if (stored)
        begin
            load_count_reg <= load_count_reg + LW'(1);
            if (pos_reg == (k_eff - KW'(1)))
            begin
                pos_reg <= '0;
                if (shard_cnt_reg != SCW'(MAX_SHARDS))
                begin
                    shard_cnt_reg <= shard_cnt_reg + SCW'(1);
                end
            end
            else
            begin
                pos_reg <= pos_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_SHARDS; s++)
            begin
                head_reg[s] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int s = 0; s < MAX_SHARDS; s++)
            begin
                head_reg[s] <= '0;
            end
        end
        else if (cmd.emit && best_found_reg)
        begin
            head_reg[best_s_reg] <= best_h_reg + KW'(1);
        end
    end

    // scan sequencing and running minimum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_s_reg     <= '0;
            r_reg          <= '0;
            p_valid_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cmd.scan_issue && cur_live;
            if (cmd.emit)
            begin
                scan_s_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_s_reg <= scan_s_reg + SW'(1);
            end
            if (cmd.clear)
            begin
                r_reg <= '0;
            end
            else if (cmd.emit)
            begin
                r_reg <= r_reg + KW'(1);
            end
            if (cmd.emit)
            begin
                best_found_reg <= 1'b0;
            end
            else if (take)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_d_reg  <= rd_d_reg;
            best_id_reg <= rd_id_reg;
            best_s_reg  <= p_s_reg;
            best_h_reg  <= p_h_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            neighbor_id_reg <= best_id_reg;
            last_result_reg <= stat.res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign neighbor_id = neighbor_id_reg;
    assign last_result = last_result_reg;

endmodule

`default_nettype wire

// ===== design/tsrm_check.sv =====
// tsrm_check: port-level assertions for topk_shard_result_merge, bound to the top.
// Depends on tsrm_pkg.
`default_nettype none

module tsrm_check (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      in_last,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic                      out_last,
    input wire logic [tsrm_pkg::ID_W-1:0] neighbor_id
);
    import tsrm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(neighbor_id) && $stable(out_last))
        else $error("stalled result changed");

    // last entry ends the load: no request taken in the next cycle
    a_load_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("request taken right after last entry");

    // results appear only from the merge, never out of the load phase
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result emitted during load");

    // a pending non-final result means the merge is still running
    a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input open while merge unfinished");

endmodule

bind topk_shard_result_merge tsrm_check u_tsrm_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_last     (in_ch.last_entry),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_last    (out_ch.last_result),
    .neighbor_id (out_ch.neighbor_id)
);

`default_nettype wire

// ===== tb/topk_shard_result_merge_tb.sv =====
// topk_shard_result_merge_tb: self-checking bench for the top-k shard result merge.
// Depends on tsrm_pkg, tsrm_in_if, tsrm_out_if and topk_shard_result_merge.
// Loads random shard lists; a scoreboard class predicts each merged neighbor id.
`default_nettype none

module topk_shard_result_merge_tb;
    import tsrm_pkg::*;

    localparam int MAX_K       = 16;
    localparam int MAX_SHARDS  = 16;
    localparam int STORE_DEPTH = MAX_K * MAX_SHARDS;

    // Idle time after the last result before touching top_k; covers a merge
    // that yields nothing plus a generous margin.
    localparam int DRAIN_CYCLES = 40;
    // Long receiver hold-off used to back the merge up into the input side.
    localparam int HOLD_CYCLES  = 300;
    // Bound on the final wait for outstanding results.
    localparam int FINAL_WAIT   = 20000;
    // Hard stop: far above the slowest legal run.
    localparam int RUN_LIMIT    = 2000000;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            last;
    } neighbor_t;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the entry stores, shard heads and
    // top_k, and queues the neighbor ids each finished load should produce.
    // ------------------------------------------------------------------
    class merge_scoreboard;
        logic [ID_W-1:0]   id_mem   [STORE_DEPTH];
        logic [DIST_W-1:0] dist_mem [STORE_DEPTH];
        int unsigned       head     [MAX_SHARDS];
        int unsigned       fill;
        logic [TOPK_W-1:0] top_k;
        neighbor_t         expected_neighbors[$];
        int                fail_count;

        function new();
            top_k      = TOPK_RESET;
            fill       = 0;
            fail_count = 0;
            foreach (head[s]) head[s] = 0;
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $time, msg);
            fail_count++;
        endtask

        function void set_top_k(input logic [TOPK_W-1:0] v);
            top_k = v;
        endfunction

        // zero acts as 1, anything above MAX_K saturates
        function int unsigned k_eff();
            int unsigned k;
            k = top_k;
            if (k == 0) k = 1;
            if (k > MAX_K) k = MAX_K;
            return k;
        endfunction

        // k-way merge over the complete shards; ties go to the lowest shard,
        // and a head at the maximum distance code is still picked
        function void merge_heads();
            int unsigned       k;
            int unsigned       shards;
            int unsigned       idx;
            int unsigned       best_s;
            logic [DIST_W-1:0] best_d;
            logic [ID_W-1:0]   best_id;
            bit                found;
            neighbor_t         nb;
            k      = k_eff();
            shards = fill / k;
            if (shards > MAX_SHARDS) shards = MAX_SHARDS;
            if (shards == 0) return;
            for (int unsigned r = 0; r < k; r++)
            begin
                found   = 1'b0;
                best_d  = '0;
                best_id = '0;
                best_s  = 0;
                for (int unsigned s = 0; s < shards; s++)
                begin
                    if (head[s] < k)
                    begin
                        idx = s * k + head[s];
                        if (idx < STORE_DEPTH && (!found || dist_mem[idx] < best_d))
                        begin
                            found   = 1'b1;
                            best_d  = dist_mem[idx];
                            best_id = id_mem[idx];
                            best_s  = s;
                        end
                    end
                end
                if (found) head[best_s]++;
                nb.id   = best_id;
                nb.last = (r + 1 == k);
                expected_neighbors.push_back(nb);
            end
        endfunction

        // one accepted input request; entries past the store end are dropped
        function void note_entry(input logic [ID_W-1:0] id,
                                 input logic [DIST_W-1:0] dist_code,
                                 input logic last);
            if (fill < STORE_DEPTH)
            begin
                id_mem[fill]   = id;
                dist_mem[fill] = dist_code;
                fill++;
            end
            if (last)
            begin
                merge_heads();
                fill = 0;
                foreach (head[s]) head[s] = 0;
            end
        endfunction

        task check_neighbor(input logic [ID_W-1:0] id, input logic last);
            neighbor_t nb;
            if (expected_neighbors.size() == 0)
            begin
                report($sformatf("unexpected result id=%h last=%b", id, last));
                return;
            end
            nb = expected_neighbors[0];
            expected_neighbors.delete(0);
            if (id !== nb.id)
                report($sformatf("neighbor_id %h, expected %h", id, nb.id));
            if (last !== nb.last)
                report($sformatf("last_result %b, expected %b (id %h)", last, nb.last, nb.id));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TOPK_W-1:0] cfg_wr_data;

    tsrm_in_if  in_ch ();
    tsrm_out_if out_ch ();

    merge_scoreboard sb = new();

    int  src_idle_pct;   // chance per cycle that the sender holds back a request
    int  sink_idle_pct;  // chance per cycle that the receiver drops ready
    bit  hold_request;   // asks the receiver for one long hold-off
    int  entries_sent;

    topk_shard_result_merge #(
        .MAX_K      (MAX_K),
        .MAX_SHARDS (MAX_SHARDS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // 10-unit clock; first rising edge at 5
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Everything is driven on the falling edge, so at the rising edge both
    // the bench and the block see settled values.
    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.entry_id   = '0;
        in_ch.distance   = '0;
        in_ch.last_entry = 1'b0;
        out_ch.ready     = 1'b0;
        hold_request     = 1'b0;
        entries_sent     = 0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Monitor: log accepted input requests into the predictor, check every
    // accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_entry(in_ch.entry_id, in_ch.distance, in_ch.last_entry);
            if (out_ch.valid && out_ch.ready)
                sb.check_neighbor(out_ch.neighbor_id, out_ch.last_result);
        end
    end

    // Receiver: random ready per the current idle rate; on request, holds
    // ready low for HOLD_CYCLES, counted here, while the sender keeps going.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All of them are entered and left on a falling edge.
    // ------------------------------------------------------------------

    // Offer one request and hold it until accepted. valid stays high on
    // return so back-to-back requests do not bounce it.
    task automatic send_entry(input logic [ID_W-1:0] id, input logic [DIST_W-1:0] dist_code,
                              input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.entry_id   = id;
        in_ch.distance   = dist_code;
        in_ch.last_entry = last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        entries_sent++;
        @(negedge clk);
    endtask

    // Wait until every expected result has been taken, then let the block
    // settle (covers merges that produce nothing).
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (sb.expected_neighbors.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_top_k(input logic [TOPK_W-1:0] v);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_top_k(v);
    endtask

    // Mix of full-range, tiny (tie-prone) and near-maximum distance codes.
    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(3);
            2:       return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(1000);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // One load: `shards` complete lists of top_k entries plus `extra` trailing
    // entries; ordered lists ascend (saturating at the max code), otherwise
    // distances are random. The final request carries last_entry.
    task automatic send_load(input int unsigned shards, input int unsigned extra,
                             input bit ordered);
        int unsigned       k;
        int unsigned       total;
        logic [DIST_W:0]   sum;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] step;
        k     = sb.k_eff();
        total = shards * k + extra;
        if (total == 0) total = 1;
        d = '0;
        for (int unsigned i = 0; i < total; i++)
        begin
            if (!ordered || i % k == 0)
            begin
                d = pick_distance();
            end
            else
            begin
                case ($urandom_range(3))
                    0:       step = '0;
                    1:       step = $urandom_range(3);
                    2:       step = $urandom_range(1 << 20);
                    default: step = $urandom;
                endcase
                sum = {1'b0, d} + step;
                d   = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
            end
            send_entry(pick_id(), d, i == total - 1);
        end
    endtask

    // Random loads until about `budget` requests went in. Mostly well-formed
    // sorted lists; some partial tails, shard-less loads and unsorted lists.
    task automatic run_random(input int budget);
        int          start;
        int unsigned k;
        int          r;
        start = entries_sent;
        while (entries_sent - start < budget)
        begin
            if ($urandom_range(3) == 0)
                write_top_k(TOPK_W'(($urandom_range(6) == 0) ? $urandom_range(31)
                                                              : $urandom_range(1, 6)));
            k = sb.k_eff();
            r = $urandom_range(99);
            if (r < 70)
                send_load($urandom_range(1, 4), 0, 1'b1);
            else if (r < 80)
                send_load($urandom_range(1, 3), (k > 1) ? $urandom_range(1, k - 1) : 0, 1'b1);
            else if (r < 88)
                send_load(0, (k > 1) ? $urandom_range(1, k - 1) : 1, 1'b1);
            else
                send_load($urandom_range(1, 3), 0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int guard;
        @(posedge rst_n);
        @(negedge clk);

        // sender idles 23%, receiver 74%
        src_idle_pct  = 23;
        sink_idle_pct = 74;

        // top_k at its reset value: one shard of 10, extreme ids and codes
        for (int i = 0; i < 10; i++)
            send_entry((i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
                       (i == 9) ? 32'hFFFF_FFFF : i * 32'h1C00_0000, i == 9);

        // top_k = 0 acts as 1. Seventeen entries: shard count saturates at
        // MAX_SHARDS, the first sixteen all sit at the max code (tie goes to
        // shard 0) and the ignored seventeenth has distance 0.
        write_top_k(5'd0);
        for (int i = 0; i < 17; i++)
            send_entry($urandom, (i == 16) ? 32'h0 : 32'hFFFF_FFFF, i == 16);
        // equal heads across three shards
        for (int i = 0; i < 3; i++)
            send_entry($urandom, 32'd5, i == 2);

        // top_k = 1: lone entry at the max code still comes out
        write_top_k(5'd1);
        send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        // top_k = 16: two full shards, then the receiver stalls for a long
        // stretch while the next load is already being offered, backing the
        // block up into its input.
        write_top_k(5'd16);
        send_load(2, 0, 1'b1);
        hold_request = 1'b1;
        send_load(0, 5, 1'b1);   // no complete shard: no results

        // top_k = 31 saturates to 16; one unsorted list
        write_top_k(5'd31);
        send_load(1, 0, 1'b0);

        write_top_k(5'd3);
        run_random(8);

        // sender idles 74%, receiver 23%
        wait_drained();
        src_idle_pct  = 74;
        sink_idle_pct = 23;
        run_random(8);

        // no idling either side
        wait_drained();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(8);

        // final drain, bounded
        in_ch.valid = 1'b0;
        guard = 0;
        while (sb.expected_neighbors.size() != 0 && guard < FINAL_WAIT)
        begin
            @(negedge clk);
            guard++;
        end
        if (sb.expected_neighbors.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.expected_neighbors.size()));
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
